### rtl/chm_pkg.sv
// shared constants, codes, types and hash helpers for the chained hash map
`timescale 1ns / 1ps
package chm_pkg;

    localparam int MAX_BUCKET_LOG2_DEF = 10;
    localparam int POOL_ENTRIES_DEF    = 4096;
    localparam int MIN_BUCKET_LOG2     = 6;

    // request modes
    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_UPDATE = 3'd1;
    localparam logic [2:0] MODE_SET    = 3'd2;
    localparam logic [2:0] MODE_GET    = 3'd3;
    localparam logic [2:0] MODE_DELETE = 3'd4;

    // result status codes
    localparam logic [2:0] ST_NOT_FOUND = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_ADDED     = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_POOL_FULL = 3'd4;

    // hash selection codes
    localparam logic [1:0] HASH_MULTIPLY = 2'd0;
    localparam logic [1:0] HASH_WANG     = 2'd1;

    // register indexes
    localparam logic [1:0] REG_HASH_SELECT  = 2'd0;
    localparam logic [1:0] REG_REJECT_DUP   = 2'd1;
    localparam logic [1:0] REG_BUCKET_LOG2  = 2'd2;

    localparam logic [1:0] HASH_SELECT_RST  = 2'd1;
    localparam logic       REJECT_DUP_RST   = 1'b0;
    localparam logic [3:0] BUCKET_LOG2_RST  = 4'd10;

    localparam logic [31:0] MUL_SEED  = 32'd61;
    localparam logic [31:0] MUL_CONST = 32'h27d4eb2d;
    localparam logic [31:0] WANG_C1   = 32'h7ed55d16;
    localparam logic [31:0] WANG_C2   = 32'hc761c23c;
    localparam logic [31:0] WANG_C3   = 32'h165667b1;
    localparam logic [31:0] WANG_C4   = 32'hd3a2646c;
    localparam logic [31:0] WANG_C5   = 32'hfd7046c5;
    localparam logic [31:0] WANG_C6   = 32'hb55a4f09;

    // back end to front end control
    typedef struct packed {
        logic clearing;
        logic pop;
    } t_back_ctl;

    function automatic logic [31:0] mul_pre(input logic [31:0] k);
        logic [31:0] m;
        m = (k ^ MUL_SEED) ^ (k >> 16);
        m = m + (m << 3);
        m = m ^ (m >> 4);
        return m;
    endfunction

    function automatic logic [31:0] wang_ab(input logic [31:0] k);
        logic [31:0] a;
        a = (k + WANG_C1) + (k << 12);
        a = (a ^ WANG_C2) ^ (a >> 19);
        return a;
    endfunction

    function automatic logic [31:0] wang_cd(input logic [31:0] k);
        logic [31:0] a;
        a = (k + WANG_C3) + (k << 5);
        a = (a + WANG_C4) ^ (a << 9);
        return a;
    endfunction

    function automatic logic [31:0] wang_ef(input logic [31:0] k);
        logic [31:0] a;
        a = (k + WANG_C5) + (k << 3);
        a = (a ^ WANG_C6) ^ (a >> 16);
        return a;
    endfunction

endpackage

### rtl/chained_int_hash_map.sv
// top level of the chained integer hash map: stream ports and register file
//
// requests arrive on the s_ stream: tuser carries the mode, tdata the key and
// the value to store. each request gives exactly one result beat on the m_
// stream: tuser carries the status, tdata the value read and the entry count.
// the front end hashes the key in its states F_S1 to F_S3 and queues up to two jobs;
// the back end reads the bucket head, then one pool entry per cycle along
// the chain, allocates and appends an entry where needed (B_ALLOC, B_APPEND
// and, on a non-empty chain, B_LINK) and hands the result over in B_OUT.
// chain reads in the pool memory set the rate.
// after reset the back end sweeps the bucket heads and the free ring with
// s_tready low; register writes are taken during that time.
// a result waits in the output register while m_tready is low; the back end
// then holds and the front end keeps filling its queue until it is full.
// the user must write the registers through the apb port only while the
// block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
module chained_int_hash_map #(
    parameter int MAX_BUCKET_LOG2 = chm_pkg::MAX_BUCKET_LOG2_DEF,
    parameter int POOL_ENTRIES    = chm_pkg::POOL_ENTRIES_DEF,
    localparam int IW    = $clog2(POOL_ENTRIES),
    localparam int OUT_W = ((32 + IW + 1 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // key [31:0], value_in [63:32]
    input  logic [2:0]       s_tuser,   // mode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // value_out [31:0], entry_total above, zero pad
    output logic [2:0]       m_tuser,   // status
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [1:0] r_hash_sel;
    logic       r_reject;
    logic [3:0] r_blog2;

    chm_pkg::t_back_ctl ctl;
    logic                       q_valid;
    logic [2:0]                 q_mode;
    logic [31:0]                q_key, q_val, value_out;
    logic [MAX_BUCKET_LOG2-1:0] q_bucket;
    logic [IW:0]                entry_total;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_sel <= chm_pkg::HASH_SELECT_RST;
            r_reject   <= chm_pkg::REJECT_DUP_RST;
            r_blog2    <= chm_pkg::BUCKET_LOG2_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                chm_pkg::REG_HASH_SELECT: r_hash_sel <= pwdata[1:0];
                chm_pkg::REG_REJECT_DUP:  r_reject   <= pwdata[0];
                chm_pkg::REG_BUCKET_LOG2: r_blog2    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            chm_pkg::REG_HASH_SELECT: prdata = {30'd0, r_hash_sel};
            chm_pkg::REG_REJECT_DUP:  prdata = {31'd0, r_reject};
            chm_pkg::REG_BUCKET_LOG2: prdata = {28'd0, r_blog2};
            default:                  prdata = '0;
        endcase
    end

    chm_front #(
        .MAX_BUCKET_LOG2(MAX_BUCKET_LOG2)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_tvalid),
        .o_ready       (s_tready),
        .i_mode        (s_tuser),
        .i_key         (s_tdata[31:0]),
        .i_val         (s_tdata[63:32]),
        .i_hash_sel    (r_hash_sel),
        .i_bucket_log2 (r_blog2),
        .i_ctl         (ctl),
        .o_q_valid     (q_valid),
        .o_q_mode      (q_mode),
        .o_q_key       (q_key),
        .o_q_val       (q_val),
        .o_q_bucket    (q_bucket)
    );

    chm_back #(
        .MAX_BUCKET_LOG2(MAX_BUCKET_LOG2),
        .POOL_ENTRIES   (POOL_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_mode     (q_mode),
        .i_q_key      (q_key),
        .i_q_val      (q_val),
        .i_q_bucket   (q_bucket),
        .i_reject_dup (r_reject),
        .o_ctl        (ctl),
        .o_valid      (m_tvalid),
        .i_ready      (m_tready),
        .o_status     (m_tuser),
        .o_value      (value_out),
        .o_total      (entry_total)
    );

    assign m_tdata = OUT_W'({entry_total, value_out});
endmodule

### rtl/chm_front.sv
// front end: accepts requests, hashes the key into a bucket, queues the job
`timescale 1ns / 1ps
module chm_front #(
    parameter int MAX_BUCKET_LOG2 = chm_pkg::MAX_BUCKET_LOG2_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2:0]                 i_mode,
    input  logic [31:0]                i_key,
    input  logic [31:0]                i_val,
    input  logic [1:0]                 i_hash_sel,
    input  logic [3:0]                 i_bucket_log2,
    input  chm_pkg::t_back_ctl         i_ctl,
    output logic                       o_q_valid,
    output logic [2:0]                 o_q_mode,
    output logic [31:0]                o_q_key,
    output logic [31:0]                o_q_val,
    output logic [MAX_BUCKET_LOG2-1:0] o_q_bucket
);
    localparam int BW = MAX_BUCKET_LOG2;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_S1   = 4'b0010,
        F_S2   = 4'b0100,
        F_S3   = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;
    logic [2:0]  r_mode;
    logic [31:0] r_key, r_val, r_m, r_w;
    logic [2:0]  r_q_mode [2];
    logic [31:0] r_q_key  [2];
    logic [31:0] r_q_val  [2];
    logic [BW-1:0] r_q_bucket [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    logic        accept, push;
    logic [31:0] h_sel;
    logic [BW-1:0] mask, bucket;
    logic [4:0]  w;

    assign o_ready = (r_state == F_IDLE) && !i_ctl.clearing;
    assign accept  = i_valid && o_ready;
    assign push    = (r_state == F_S3) && (r_cnt != 2'd2);

    // clamp bucket width to the supported range
    always_comb begin
        if (i_bucket_log2 < 4'(chm_pkg::MIN_BUCKET_LOG2)) begin
            w = 5'(chm_pkg::MIN_BUCKET_LOG2);
        end else if ({1'b0, i_bucket_log2} > 5'(BW)) begin
            w = 5'(BW);
        end else begin
            w = {1'b0, i_bucket_log2};
        end
        for (int i = 0; i < BW; i++) begin
            mask[i] = (5'(i) < w);
        end
        case (i_hash_sel)
            chm_pkg::HASH_MULTIPLY: h_sel = r_m ^ (r_m >> 15);
            chm_pkg::HASH_WANG:     h_sel = chm_pkg::wang_ef(r_w);
            default:                h_sel = r_key;
        endcase
        bucket = h_sel[BW-1:0] & mask;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (accept) n_state = F_S1;
            F_S1:    n_state = F_S2;
            F_S2:    n_state = F_S3;
            F_S3:    if (push) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            if (push) r_wp <= ~r_wp;
            if (i_ctl.pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_ctl.pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_val  <= i_val;
        end
        if (r_state == F_S1) begin
            r_m <= chm_pkg::mul_pre(r_key);
            r_w <= chm_pkg::wang_ab(r_key);
        end
        if (r_state == F_S2) begin
            r_m <= r_m * chm_pkg::MUL_CONST;
            r_w <= chm_pkg::wang_cd(r_w);
        end
        if (push) begin
            r_q_mode[r_wp]   <= r_mode;
            r_q_key[r_wp]    <= r_key;
            r_q_val[r_wp]    <= r_val;
            r_q_bucket[r_wp] <= bucket;
        end
    end

    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_mode   = r_q_mode[r_rp];
    assign o_q_key    = r_q_key[r_rp];
    assign o_q_val    = r_q_val[r_rp];
    assign o_q_bucket = r_q_bucket[r_rp];
endmodule

### rtl/chm_back.sv
// back end: walks bucket chains in pool memory and applies each request
`timescale 1ns / 1ps
module chm_back #(
    parameter int MAX_BUCKET_LOG2 = chm_pkg::MAX_BUCKET_LOG2_DEF,
    parameter int POOL_ENTRIES    = chm_pkg::POOL_ENTRIES_DEF,
    localparam int IW = $clog2(POOL_ENTRIES)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  logic [2:0]                 i_q_mode,
    input  logic [31:0]                i_q_key,
    input  logic [31:0]                i_q_val,
    input  logic [MAX_BUCKET_LOG2-1:0] i_q_bucket,
    input  logic                       i_reject_dup,
    output chm_pkg::t_back_ctl         o_ctl,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0]                 o_status,
    output logic [31:0]                o_value,
    output logic [IW:0]                o_total
);
    localparam int BW    = MAX_BUCKET_LOG2;
    localparam int NB    = 2 ** BW;
    localparam int CLR_N = (NB > POOL_ENTRIES) ? NB : POOL_ENTRIES;
    localparam int CLR_W = $clog2(CLR_N);
    localparam logic [IW:0] END_MARK = (IW + 1)'(POOL_ENTRIES);

    typedef enum logic [7:0] {
        B_CLR    = 8'b00000001,
        B_IDLE   = 8'b00000010,
        B_HEAD   = 8'b00000100,
        B_WALK   = 8'b00001000,
        B_ALLOC  = 8'b00010000,
        B_APPEND = 8'b00100000,
        B_LINK   = 8'b01000000,
        B_OUT    = 8'b10000000
    } t_bstate;

    logic [IW:0]   mem_head [NB];
    logic [IW-1:0] mem_tail [NB];
    logic [31:0]   mem_key  [POOL_ENTRIES];
    logic [31:0]   mem_val  [POOL_ENTRIES];
    logic [IW:0]   mem_link [POOL_ENTRIES];
    logic [IW-1:0] mem_ring [POOL_ENTRIES];

    logic [IW:0]   head_q, link_q;
    logic [IW-1:0] tail_q, ring_q;
    logic [31:0]   key_q, val_q;

    t_bstate r_state, n_state;
    logic [CLR_W-1:0] r_clr;
    logic [2:0]    r_mode, r_status, n_status;
    logic [31:0]   r_key, r_val;
    logic [BW-1:0] r_b;
    logic [IW:0]   r_head, r_cur, r_prev, n_cur, n_prev;
    logic [IW-1:0] r_tail, r_e;
    logic [IW-1:0] r_free_rd, r_free_wr;
    logic [IW:0]   r_free, r_live;
    logic          r_ov;
    logic [31:0]   r_vout, r_ovalue, n_vout;
    logic [2:0]    r_ostatus;
    logic [IW:0]   r_ototal;

    logic          take, hit, do_del, do_upd, do_app;
    logic [BW-1:0] head_ra;
    logic [IW-1:0] ent_ra;

    // write ports
    logic          head_we, tail_we, link_we, key_we, val_we, ring_we;
    logic [BW-1:0] head_wa, tail_wa;
    logic [IW-1:0] link_wa, val_wa, ring_wa, tail_wd, ring_wd;
    logic [IW:0]   head_wd, link_wd;

    assign take  = (r_state == B_IDLE) && i_q_valid;
    assign hit   = (key_q == r_key);
    assign o_ctl = '{clearing: (r_state == B_CLR), pop: take};

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
        return (p == IW'(POOL_ENTRIES - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head_ra = take ? i_q_bucket : r_b;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_vout   = r_vout;
        n_cur    = r_cur;
        n_prev   = r_prev;
        ent_ra   = r_cur[IW-1:0];
        do_del   = 1'b0;
        do_upd   = 1'b0;
        do_app   = 1'b0;
        case (r_state)
            B_CLR: begin
                if (r_clr == CLR_W'(CLR_N - 1)) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (take) n_state = B_HEAD;
                n_status = chm_pkg::ST_NOT_FOUND;
                n_vout   = '0;
            end
            B_HEAD: begin
                n_prev = END_MARK;
                n_cur  = head_q;
                ent_ra = head_q[IW-1:0];
                if (r_mode > chm_pkg::MODE_DELETE) begin
                    n_state = B_OUT;
                end else if (r_mode == chm_pkg::MODE_ADD && !i_reject_dup) begin
                    do_app = 1'b1;
                end else if (head_q == END_MARK) begin
                    if (r_mode == chm_pkg::MODE_ADD || r_mode == chm_pkg::MODE_SET) begin
                        do_app = 1'b1;
                    end else begin
                        n_state = B_OUT;
                    end
                end else begin
                    n_state = B_WALK;
                end
            end
            B_WALK: begin
                if (hit) begin
                    n_state  = B_OUT;
                    n_status = chm_pkg::ST_FOUND;
                    case (r_mode)
                        chm_pkg::MODE_ADD:    n_status = chm_pkg::ST_DUPLICATE;
                        chm_pkg::MODE_GET:    n_vout = val_q;
                        chm_pkg::MODE_DELETE: do_del = 1'b1;
                        default:              do_upd = 1'b1;
                    endcase
                end else if (link_q == END_MARK) begin
                    if (r_mode == chm_pkg::MODE_ADD || r_mode == chm_pkg::MODE_SET) begin
                        do_app = 1'b1;
                    end else begin
                        n_state = B_OUT;
                    end
                end else begin
                    n_prev = r_cur;
                    n_cur  = link_q;
                    ent_ra = link_q[IW-1:0];
                end
            end
            B_ALLOC:  n_state = B_APPEND;
            B_APPEND: n_state = (r_head == END_MARK) ? B_OUT : B_LINK;
            B_LINK:   n_state = B_OUT;
            B_OUT:    if (!r_ov || i_ready) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
        if (do_app) begin
            if (r_free == '0) begin
                n_state  = B_OUT;
                n_status = chm_pkg::ST_POOL_FULL;
            end else begin
                n_state  = B_ALLOC;
                n_status = chm_pkg::ST_ADDED;
            end
        end
    end

    // memory write port selection
    always_comb begin
        head_we = 1'b0; head_wa = r_b; head_wd = {1'b0, ring_q};
        tail_we = 1'b0; tail_wa = r_b; tail_wd = ring_q;
        link_we = 1'b0; link_wa = ring_q; link_wd = END_MARK;
        key_we  = 1'b0;
        val_we  = 1'b0; val_wa = ring_q;
        ring_we = 1'b0; ring_wa = r_free_wr; ring_wd = r_cur[IW-1:0];
        if (r_state == B_CLR) begin
            head_we = ({1'b0, r_clr} < (CLR_W + 1)'(NB));
            head_wa = r_clr[BW-1:0];
            head_wd = END_MARK;
            ring_we = ({1'b0, r_clr} < (CLR_W + 1)'(POOL_ENTRIES));
            ring_wa = r_clr[IW-1:0];
            ring_wd = r_clr[IW-1:0];
        end
        if (r_state == B_APPEND) begin
            key_we  = 1'b1;
            val_we  = 1'b1;
            link_we = 1'b1;
            tail_we = 1'b1;
            head_we = (r_head == END_MARK);
        end
        if (r_state == B_LINK) begin
            link_we = 1'b1;
            link_wa = r_tail;
            link_wd = {1'b0, r_e};
        end
        if (do_upd) begin
            val_we = 1'b1;
            val_wa = r_cur[IW-1:0];
        end
        if (do_del) begin
            ring_we = 1'b1;
            if (r_prev == END_MARK) begin
                head_we = 1'b1;
                head_wd = link_q;
            end else begin
                link_we = 1'b1;
                link_wa = r_prev[IW-1:0];
                link_wd = link_q;
                tail_we = (r_tail == r_cur[IW-1:0]);
                tail_wd = r_prev[IW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) mem_head[head_wa] <= head_wd;
        head_q <= mem_head[head_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tail_we) mem_tail[tail_wa] <= tail_wd;
        tail_q <= mem_tail[head_ra];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) mem_key[ring_q] <= r_key;
        key_q <= mem_key[ent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) mem_val[val_wa] <= r_val;
        val_q <= mem_val[ent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (link_we) mem_link[link_wa] <= link_wd;
        link_q <= mem_link[ent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) mem_ring[ring_wa] <= ring_wd;
        ring_q <= mem_ring[r_free_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_CLR;
            r_clr     <= '0;
            r_free_rd <= '0;
            r_free_wr <= '0;
            r_free    <= END_MARK;
            r_live    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLR) r_clr <= r_clr + 1'b1;
            if (r_state == B_APPEND) begin
                r_free_rd <= ring_next(r_free_rd);
                r_free    <= r_free - 1'b1;
                r_live    <= r_live + 1'b1;
            end
            if (do_del) begin
                r_free_wr <= ring_next(r_free_wr);
                r_free    <= r_free + 1'b1;
                r_live    <= r_live - 1'b1;
            end
            if (r_state == B_OUT && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_vout   <= n_vout;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        if (take) begin
            r_mode <= i_q_mode;
            r_key  <= i_q_key;
            r_val  <= i_q_val;
            r_b    <= i_q_bucket;
        end
        if (r_state == B_HEAD) begin
            r_head <= head_q;
            r_tail <= tail_q;
        end
        if (r_state == B_APPEND) r_e <= ring_q;
        if (r_state == B_OUT && (!r_ov || i_ready)) begin
            r_ostatus <= r_status;
            r_ovalue  <= r_vout;
            r_ototal  <= r_live;
        end
    end

    assign o_valid  = r_ov;
    assign o_status = r_ostatus;
    assign o_value  = r_ovalue;
    assign o_total  = r_ototal;
endmodule
